/* src/rwcp_pkg.sv */
`default_nettype none

package rwcp_pkg;

    localparam int POSITION_BITS_DEFAULT = 34;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam int FMT_CAPTURE = 16;

    typedef enum logic [2:0] {
        KIND_DATA_START = 3'd0,
        KIND_SAMPLE     = 3'd1,
        KIND_REPORT     = 3'd2,
        KIND_NOT_WAVE   = 3'd3,
        KIND_TRUNC_FMT  = 3'd4
    } rwcp_kind_t;

    typedef struct packed {
        rwcp_kind_t  kind;
        logic [7:0]  sample;
        logic [15:0] fmt_tag;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] sample_bits;
        logic        last;
    } rwcp_result_t;

    typedef struct packed {
        logic [1:0]   count;
        rwcp_result_t first;
        rwcp_result_t second;
    } rwcp_push_t;

endpackage

`default_nettype wire

/* src/rwcp_core.sv */
`default_nettype none

module rwcp_core #(
    parameter int POSITION_BITS = rwcp_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         data_byte,
    input  wire logic               final_byte,
    output rwcp_pkg::rwcp_push_t    push
);

    localparam int P  = POSITION_BITS;
    localparam int SW = ((P > 32) ? P : 32) + 2;
    localparam logic [P-1:0] POS_MAX = '1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_WALK,
        PH_REJECT
    } phase_t;

    typedef enum logic [1:0] {
        CK_NONE,
        CK_FMT,
        CK_DATA
    } chunk_t;

    phase_t       phase_reg, phase_next;
    chunk_t       chunk_reg, chunk_next;
    logic [P-1:0] pos_reg, pos_next;
    logic [P-1:0] riff_end_reg, riff_end_next;
    logic [P-1:0] nha_reg, nha_next;
    logic [P:0]   cbe_reg, cbe_next;
    logic [63:0]  shift_reg, shift_next;
    logic [15:0]  ftag_reg, ftag_next;
    logic [15:0]  chan_reg, chan_next;
    logic [31:0]  rate_reg, rate_next;
    logic [15:0]  bits_reg, bits_next;

    logic [P:0]    p_ext;
    logic [P-1:0]  body;
    logic [31:0]   low;
    logic [31:0]   size;
    logic [3:0]    off;
    logic [SW-1:0] riff_sum;
    logic [SW-1:0] data_sum;
    logic [SW-1:0] next_sum;
    logic          live;
    logic          hdr_hit;
    logic          slot0_valid;
    rwcp_pkg::rwcp_result_t slot0;
    rwcp_pkg::rwcp_result_t fin_res;

    always_comb
    begin
        phase_next    = phase_reg;
        chunk_next    = chunk_reg;
        pos_next      = pos_reg;
        riff_end_next = riff_end_reg;
        nha_next      = nha_reg;
        cbe_next      = cbe_reg;
        shift_next    = shift_reg;
        ftag_next     = ftag_reg;
        chan_next     = chan_reg;
        rate_next     = rate_reg;
        bits_next     = bits_reg;
        slot0_valid   = 1'b0;
        slot0         = '0;
        fin_res       = '0;
        push          = '0;

        live     = (pos_reg != POS_MAX);
        p_ext    = {1'b0, pos_reg};
        body     = pos_reg + P'(1);
        low      = {shift_reg[23:0], data_byte};
        size     = {low[7:0], low[15:8], low[23:16], low[31:24]};
        off      = 4'(p_ext - cbe_reg);
        riff_sum = SW'(8) + SW'(size);
        data_sum = SW'(body) + SW'(size);
        next_sum = data_sum + SW'(size[0]);
        hdr_hit  = ((({1'b0, nha_reg}) + (P+1)'(7)) == p_ext)
                && ((({1'b0, nha_reg}) + (P+1)'(8)) <= {1'b0, riff_end_reg});

        if (live)
        begin
            pos_next   = body;
            shift_next = {shift_reg[55:0], data_byte};
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == P'(3) && low != rwcp_pkg::TAG_RIFF)
                        phase_next = PH_REJECT;
                    else if (pos_reg == P'(7))
                        riff_end_next = (riff_sum > SW'(POS_MAX)) ? POS_MAX : riff_sum[P-1:0];
                    else if (pos_reg == P'(11))
                        phase_next = (low == rwcp_pkg::TAG_WAVE) ? PH_WALK : PH_REJECT;
                end
                PH_WALK:
                begin
                    if (chunk_reg == CK_FMT && p_ext < cbe_reg)
                    begin
                        if (off < 4'd2)
                        begin
                            if (off[0]) ftag_next[15:8] = data_byte;
                            else        ftag_next[7:0]  = data_byte;
                        end
                        else if (off < 4'd4)
                        begin
                            if (off[0]) chan_next[15:8] = data_byte;
                            else        chan_next[7:0]  = data_byte;
                        end
                        else if (off < 4'd8)
                        begin
                            rate_next[off[1:0]*8 +: 8] = data_byte;
                        end
                        else if (off >= 4'd14)
                        begin
                            if (off[0]) bits_next[15:8] = data_byte;
                            else        bits_next[7:0]  = data_byte;
                        end
                        if ((p_ext + (P+1)'(1)) >= cbe_reg)
                            chunk_next = CK_NONE;
                    end
                    else if (chunk_reg == CK_DATA && p_ext < cbe_reg)
                    begin
                        slot0_valid  = 1'b1;
                        slot0.kind   = rwcp_pkg::KIND_SAMPLE;
                        slot0.sample = data_byte;
                        if ((p_ext + (P+1)'(1)) >= cbe_reg)
                            chunk_next = CK_NONE;
                    end
                    if (hdr_hit)
                    begin
                        if (shift_next[63:32] == rwcp_pkg::TAG_FMT
                            && size >= 32'(rwcp_pkg::FMT_CAPTURE))
                        begin
                            chunk_next = CK_FMT;
                            cbe_next   = {1'b0, body} + (P+1)'(rwcp_pkg::FMT_CAPTURE);
                        end
                        else if (shift_next[63:32] == rwcp_pkg::TAG_DATA)
                        begin
                            slot0_valid = 1'b1;
                            slot0.kind  = rwcp_pkg::KIND_DATA_START;
                            cbe_next    = {1'b0, (data_sum > SW'(POS_MAX)) ? POS_MAX
                                                                        : data_sum[P-1:0]};
                            chunk_next  = (size != 32'd0) ? CK_DATA : CK_NONE;
                        end
                        else
                        begin
                            chunk_next = CK_NONE;
                        end
                        nha_next = (next_sum > SW'(POS_MAX)) ? POS_MAX : next_sum[P-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (phase_next != PH_WALK)
            fin_res.kind = rwcp_pkg::KIND_NOT_WAVE;
        else if (chunk_next == CK_FMT)
            fin_res.kind = rwcp_pkg::KIND_TRUNC_FMT;
        else
        begin
            fin_res.kind        = rwcp_pkg::KIND_REPORT;
            fin_res.fmt_tag     = ftag_next;
            fin_res.channels    = chan_next;
            fin_res.rate        = rate_next;
            fin_res.sample_bits = bits_next;
        end
        fin_res.last = 1'b1;

        if (accept)
        begin
            if (slot0_valid)
            begin
                push.first      = slot0;
                push.first.last = !final_byte;
                push.second     = fin_res;
                push.count      = final_byte ? 2'd2 : 2'd1;
            end
            else if (final_byte)
            begin
                push.first = fin_res;
                push.count = 2'd1;
            end
        end

        if (final_byte)
        begin
            phase_next    = PH_HEADER;
            chunk_next    = CK_NONE;
            pos_next      = '0;
            riff_end_next = '0;
            nha_next      = P'(12);
            cbe_next      = '0;
            shift_next    = '0;
            ftag_next     = '0;
            chan_next     = '0;
            rate_next     = '0;
            bits_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            chunk_reg    <= CK_NONE;
            pos_reg      <= '0;
            riff_end_reg <= '0;
            nha_reg      <= P'(12);
            cbe_reg      <= '0;
            shift_reg    <= '0;
            ftag_reg     <= '0;
            chan_reg     <= '0;
            rate_reg     <= '0;
            bits_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            chunk_reg    <= chunk_next;
            pos_reg      <= pos_next;
            riff_end_reg <= riff_end_next;
            nha_reg      <= nha_next;
            cbe_reg      <= cbe_next;
            shift_reg    <= shift_next;
            ftag_reg     <= ftag_next;
            chan_reg     <= chan_next;
            rate_reg     <= rate_next;
            bits_reg     <= bits_next;
        end
    end

    // chunks are only open while walking
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_WALK) |-> (chunk_reg == CK_NONE))
        else $error("chunk open outside chunk walk");

    // an open fmt capture ends within sixteen bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (chunk_reg == CK_FMT) |-> ((cbe_reg > p_ext)
            && ((cbe_reg - p_ext) <= (P+1)'(rwcp_pkg::FMT_CAPTURE))))
        else $error("fmt capture window out of range");

endmodule

`default_nettype wire

/* src/rwcp_queue.sv */
`default_nettype none

module rwcp_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rwcp_pkg::rwcp_push_t   push,
    input  wire logic                   pop,
    output logic                        space,
    output logic                        valid,
    output rwcp_pkg::rwcp_result_t      head
);

    localparam int DEPTH = rwcp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rwcp_pkg::rwcp_result_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign valid  = (count_reg != '0);
    assign space  = (count_reg <= CNT_W'(DEPTH - 2));
    assign head   = entry_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overfilled");

    // words are pushed only when two slots are free
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> space)
        else $error("push without room");

endmodule

`default_nettype wire

/* src/riff_wave_chunk_parser.sv */
`default_nettype none

// channel  | handshake                   | payload
// ---------+-----------------------------+------------------------------------------
// byte in  | byte_valid / byte_stall     | data_byte, final_byte
// result   | result_valid / result_stall | result_kind, sample_byte, format_tag,
//          |                             | channel_count, sample_rate,
//          |                             | bits_per_sample, last_of_run
//
// One byte per cycle while byte_stall is low; each byte is parsed in the cycle it is taken.
// Results go to a 4-word queue and leave one word per cycle while result_stall is low.
// A final byte that also carries a sample or data start makes two words.
// byte_stall is high while fewer than two queue slots are free.
// Reset clears the parse state and empties the queue.

module riff_wave_chunk_parser #(
    parameter int POSITION_BITS = rwcp_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [2:0]       result_kind,
    output logic [7:0]       sample_byte,
    output logic [15:0]      format_tag,
    output logic [15:0]      channel_count,
    output logic [31:0]      sample_rate,
    output logic [15:0]      bits_per_sample,
    output logic             last_of_run
);

    rwcp_pkg::rwcp_push_t   push;
    rwcp_pkg::rwcp_result_t head;
    logic                   space;
    logic                   accept;

    assign byte_stall = !space;
    assign accept     = byte_valid && space;

    rwcp_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .push       (push)
    );

    rwcp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (!result_stall),
        .space (space),
        .valid (result_valid),
        .head  (head)
    );

    assign result_kind     = head.kind;
    assign sample_byte     = head.sample;
    assign format_tag      = head.fmt_tag;
    assign channel_count   = head.channels;
    assign sample_rate     = head.rate;
    assign bits_per_sample = head.sample_bits;
    assign last_of_run     = head.last;

endmodule

`default_nettype wire

/* verif/riff_wave_result_checker.sv */
module riff_wave_result_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    input  wire logic        byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    input  wire logic        result_valid,
    input  wire logic        result_stall,
    input  wire logic [2:0]  result_kind,
    input  wire logic [7:0]  sample_byte,
    input  wire logic [15:0] format_tag,
    input  wire logic [15:0] channel_count,
    input  wire logic [31:0] sample_rate,
    input  wire logic [15:0] bits_per_sample,
    input  wire logic        last_of_run,
    output int               mismatches,
    output int               pending,
    output int               words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] POS_LIMIT =
        (64'd1 << rwcp_pkg::POSITION_BITS_DEFAULT) - 64'd1;

    typedef enum logic [1:0] {
        PHASE_HEADER,
        PHASE_CHUNKS,
        PHASE_REJECTED
    } parse_phase_t;

    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_FMT,
        BODY_DATA
    } body_kind_t;

    logic [63:0]  position;
    logic [63:0]  riff_end;
    logic [63:0]  next_header;
    logic [63:0]  body_end;
    logic [63:0]  recent_bytes;
    body_kind_t   body;
    parse_phase_t phase;
    logic [15:0]  fmt_tag_q;
    logic [15:0]  channels_q;
    logic [31:0]  rate_q;
    logic [15:0]  sample_bits_q;

    rwcp_pkg::rwcp_result_t expected_words[$];
    rwcp_pkg::rwcp_result_t oldest;
    int                     fail_count = 0;
    int                     checked_count = 0;

    function automatic logic [31:0] swap_bytes(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [63:0] clamp_position(input logic [63:0] v);
        return (v > POS_LIMIT) ? POS_LIMIT : v;
    endfunction

    function automatic rwcp_pkg::rwcp_result_t make_word(input rwcp_pkg::rwcp_kind_t kind,
                                                         input logic [7:0] sample,
                                                         input logic report);
        rwcp_pkg::rwcp_result_t w;
        w = '0;
        w.kind = kind;
        w.sample = sample;
        if (report)
        begin
            w.fmt_tag = fmt_tag_q;
            w.channels = channels_q;
            w.rate = rate_q;
            w.sample_bits = sample_bits_q;
        end
        return w;
    endfunction

    task automatic restart_file();
        position = '0;
        riff_end = '0;
        next_header = 64'd12;
        recent_bytes = '0;
        body_end = '0;
        body = BODY_NONE;
        phase = PHASE_HEADER;
        fmt_tag_q = '0;
        channels_q = '0;
        rate_q = '0;
        sample_bits_q = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fin);
        logic [63:0]  p;
        logic [63:0]  size;
        logic [63:0]  body_start;
        logic [31:0]  low;
        logic [3:0]   offset;
        rwcp_pkg::rwcp_result_t words[$];
        p = position;
        if (p < POS_LIMIT)
        begin
            position = p + 64'd1;
            recent_bytes = {recent_bytes[55:0], b};
            low = recent_bytes[31:0];
            case (phase)
                PHASE_HEADER:
                begin
                    if (p == 64'd3 && low != rwcp_pkg::TAG_RIFF)
                        phase = PHASE_REJECTED;
                    else if (p == 64'd7)
                        riff_end = clamp_position(64'd8 + 64'(swap_bytes(low)));
                    else if (p == 64'd11)
                        phase = (low == rwcp_pkg::TAG_WAVE) ? PHASE_CHUNKS : PHASE_REJECTED;
                end
                PHASE_CHUNKS:
                begin
                    if (body == BODY_FMT && p < body_end)
                    begin
                        offset = 4'(p - (body_end - rwcp_pkg::FMT_CAPTURE));
                        if (offset < 4'd2)
                            fmt_tag_q[8 * offset[0] +: 8] = b;
                        else if (offset < 4'd4)
                            channels_q[8 * offset[0] +: 8] = b;
                        else if (offset < 4'd8)
                            rate_q[8 * (int'(offset) - 4) +: 8] = b;
                        else if (offset >= 4'd14)
                            sample_bits_q[8 * offset[0] +: 8] = b;
                        if (p + 64'd1 >= body_end)
                            body = BODY_NONE;
                    end
                    else if (body == BODY_DATA && p < body_end)
                    begin
                        words = {words, make_word(rwcp_pkg::KIND_SAMPLE, b, 1'b0)};
                        if (p + 64'd1 >= body_end)
                            body = BODY_NONE;
                    end
                    if (next_header + 64'd7 == p && next_header + 64'd8 <= riff_end)
                    begin
                        size = 64'(swap_bytes(low));
                        body_start = p + 64'd1;
                        if (recent_bytes[63:32] == rwcp_pkg::TAG_FMT
                            && size >= rwcp_pkg::FMT_CAPTURE)
                        begin
                            body = BODY_FMT;
                            body_end = body_start + rwcp_pkg::FMT_CAPTURE;
                        end
                        else if (recent_bytes[63:32] == rwcp_pkg::TAG_DATA)
                        begin
                            words = {words, make_word(rwcp_pkg::KIND_DATA_START, 8'd0, 1'b0)};
                            body_end = clamp_position(body_start + size);
                            body = (size != 0) ? BODY_DATA : BODY_NONE;
                        end
                        else
                            body = BODY_NONE;
                        next_header = clamp_position(body_start + size + 64'(size[0]));
                    end
                end
                default: ;
            endcase
        end
        if (fin)
        begin
            if (phase != PHASE_CHUNKS)
                words = {words, make_word(rwcp_pkg::KIND_NOT_WAVE, 8'd0, 1'b0)};
            else if (body == BODY_FMT)
                words = {words, make_word(rwcp_pkg::KIND_TRUNC_FMT, 8'd0, 1'b0)};
            else
                words = {words, make_word(rwcp_pkg::KIND_REPORT, 8'd0, 1'b1)};
            restart_file();
        end
        if (words.size() != 0)
            words[words.size() - 1].last = 1'b1;
        expected_words = {expected_words, words};
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin
        restart_file();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                parse_byte(data_byte, final_byte);
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with none expected, result_kind %0d", result_kind);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_words.pop_front();
                    check_field("result_kind", 32'(oldest.kind), 32'(result_kind));
                    check_field("sample_byte", 32'(oldest.sample), 32'(sample_byte));
                    check_field("format_tag", 32'(oldest.fmt_tag), 32'(format_tag));
                    check_field("channel_count", 32'(oldest.channels), 32'(channel_count));
                    check_field("sample_rate", oldest.rate, sample_rate);
                    check_field("bits_per_sample", 32'(oldest.sample_bits),
                                32'(bits_per_sample));
                    check_field("last_of_run", 32'(oldest.last), 32'(last_of_run));
                    checked_count++;
                end
            end
            mismatches <= fail_count;
            pending <= expected_words.size();
            words_checked <= checked_count;
        end
    end

endmodule

/* verif/riff_wave_chunk_parser_tb.sv */
module riff_wave_chunk_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_TARGET    = 1850;
    localparam int HOLD_OFF_SPAN  = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  data_byte;
    logic        final_byte;
    logic        result_valid;
    logic        result_stall;
    logic [2:0]  result_kind;
    logic [7:0]  sample_byte;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic        last_of_run;

    int mismatches;
    int pending;
    int words_checked;

    logic [7:0] file_bytes[$];
    int         burst_left = 0;
    int         bytes_sent = 0;
    int         files_sent = 0;
    int         idle_cycles = 0;
    bit         hold_off_req = 1'b0;
    bit         hold_off_done = 1'b0;

    riff_wave_chunk_parser DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .data_byte       (data_byte),
        .final_byte      (final_byte),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result_kind     (result_kind),
        .sample_byte     (sample_byte),
        .format_tag      (format_tag),
        .channel_count   (channel_count),
        .sample_rate     (sample_rate),
        .bits_per_sample (bits_per_sample),
        .last_of_run     (last_of_run)
    );

    riff_wave_result_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .data_byte       (data_byte),
        .final_byte      (final_byte),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result_kind     (result_kind),
        .sample_byte     (sample_byte),
        .format_tag      (format_tag),
        .channel_count   (channel_count),
        .sample_rate     (sample_rate),
        .bits_per_sample (bits_per_sample),
        .last_of_run     (last_of_run),
        .mismatches      (mismatches),
        .pending         (pending),
        .words_checked   (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic add_byte(input logic [7:0] b);
        file_bytes = {file_bytes, b};
    endtask

    task automatic put_tag(input logic [31:0] tag);
        add_byte(tag[31:24]);
        add_byte(tag[23:16]);
        add_byte(tag[15:8]);
        add_byte(tag[7:0]);
    endtask

    task automatic put_le(input logic [31:0] w);
        add_byte(w[7:0]);
        add_byte(w[15:8]);
        add_byte(w[23:16]);
        add_byte(w[31:24]);
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 48);
                if ($urandom_range(0, 3) != 0)
                begin
                    byte_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            burst_left--;
            byte_valid <= 1'b1;
            data_byte <= file_bytes[i];
            final_byte <= (i == file_bytes.size() - 1);
            @(posedge clk);
            while (byte_stall)
                @(posedge clk);
            bytes_sent++;
        end
        files_sent++;
    endtask

    task automatic drain_results();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // mostly well-formed files with random content; some noise, bad tags and cut-offs
    task automatic build_file();
        int unsigned chunk_count;
        int unsigned size;
        int unsigned body_len;
        int unsigned cut;
        logic [31:0] tag;
        logic [31:0] riff_size;
        int          header_ends[$];
        file_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 16))
                add_byte(8'($urandom));
            return;
        end
        tag = rwcp_pkg::TAG_RIFF;
        if ($urandom_range(0, 15) == 0)
            tag[$urandom_range(0, 31)] ^= 1'b1;
        put_tag(tag);
        put_le(32'd0);
        tag = rwcp_pkg::TAG_WAVE;
        if ($urandom_range(0, 15) == 0)
            tag[$urandom_range(0, 31)] ^= 1'b1;
        put_tag(tag);
        chunk_count = $urandom_range(0, 4);
        repeat (chunk_count)
        begin
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    tag = rwcp_pkg::TAG_FMT;
                    size = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 15)
                                                       : $urandom_range(16, 22);
                end
                2, 3:
                begin
                    tag = rwcp_pkg::TAG_DATA;
                    size = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 13);
                end
                4:
                begin
                    tag = $urandom;
                    size = $urandom_range(0, 7);
                end
                default:
                begin
                    tag = $urandom_range(0, 1) ? rwcp_pkg::TAG_FMT : rwcp_pkg::TAG_DATA;
                    tag[$urandom_range(0, 31)] ^= 1'b1;
                    size = $urandom_range(0, 7);
                end
            endcase
            put_tag(tag);
            put_le(size);
            header_ends = {header_ends, int'(file_bytes.size())};
            body_len = (size > 40) ? $urandom_range(0, 24) : size + size[0];
            repeat (body_len)
                add_byte(8'($urandom));
        end
        case ($urandom_range(0, 7))
            0: riff_size = $urandom_range(0, file_bytes.size());
            1: riff_size = $urandom;
            default: riff_size = file_bytes.size() - 8;
        endcase
        file_bytes[4] = riff_size[7:0];
        file_bytes[5] = riff_size[15:8];
        file_bytes[6] = riff_size[23:16];
        file_bytes[7] = riff_size[31:24];
        cut = file_bytes.size();
        case ($urandom_range(0, 9))
            0, 1: cut = $urandom_range(1, file_bytes.size());
            2:
            begin
                if (header_ends.size() != 0)
                    cut = header_ends[$urandom_range(0, header_ends.size() - 1)];
            end
            3:
            begin
                repeat ($urandom_range(1, 6))
                    add_byte(8'($urandom));
                cut = file_bytes.size();
            end
            default: ;
        endcase
        while (file_bytes.size() > cut)
            void'(file_bytes.pop_back());
    endtask

    initial
    begin
        rst_n <= 1'b0;
        byte_valid <= 1'b0;
        data_byte <= 8'd0;
        final_byte <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte file
        file_bytes = '{8'hFF};
        send_file();
        // fmt header ends on the final byte
        file_bytes.delete();
        put_tag(rwcp_pkg::TAG_RIFF);
        put_le(32'hFFFF_FFFF);
        put_tag(rwcp_pkg::TAG_WAVE);
        put_tag(rwcp_pkg::TAG_FMT);
        put_le(32'd16);
        send_file();
        // bad RIFF tag, cut short
        file_bytes.delete();
        put_tag(rwcp_pkg::TAG_RIFF ^ 32'h0000_0001);
        send_file();
        drain_results();

        hold_off_req = 1'b1;
        while (bytes_sent < BYTE_TARGET)
        begin
            build_file();
            send_file();
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end
        drain_results();
        repeat (20) @(posedge clk);

        $display("%0d files, %0d bytes sent in bursts against a stalling sink; %0d words compared",
                 files_sent, bytes_sent, words_checked);
        if (mismatches == 0 && pending == 0)
            $display("riff_wave_chunk_parser_tb OK");
        else
            $display("riff_wave_chunk_parser_tb NOT OK");
        $finish;
    end

    initial
    begin
        int unsigned mode;
        int          tick;
        tick = 0;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_OFF_SPAN) @(posedge clk);
                hold_off_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200))
            begin
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    2: result_stall <= ($urandom_range(0, 3) != 0);
                    default: result_stall <= ((tick % 6) < 2);
                endcase
                tick++;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("riff_wave_chunk_parser_tb NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

/* sim.f */
src/rwcp_pkg.sv
src/rwcp_core.sv
src/rwcp_queue.sv
src/riff_wave_chunk_parser.sv
verif/riff_wave_result_checker.sv
verif/riff_wave_chunk_parser_tb.sv
